### rtl/core/tbcc_pkg.sv
// ----------------------------------------------------------------------------
// tbcc_pkg
// Shared types and constants of the tile and box collision check.
// ----------------------------------------------------------------------------
package tbcc_pkg;

    localparam int MAX_ENTITIES_DEF = 16;

    // background map is a fixed 32 x 32 grid of 8-bit tile ids
    localparam int MAP_CELLS   = 32;
    localparam int MAP_ADDR_W  = 10;
    localparam int SOLID_ROWS  = 32;
    localparam int SOLID_ROW_W = 5;
    localparam int COUNT_W     = 5;
    localparam int SLOT_W      = 5;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_MARK   = 3'd1,
        OP_MAP_WR = 3'd2,
        OP_ENT_WR = 3'd3,
        OP_QUERY  = 3'd4,
        OP_IDLE   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_SOLID,
        ST_TEST,
        ST_ENT
    } state_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
        logic       active;
        logic       solid;
    } ent_rec_t;

endpackage

### rtl/core/tile_and_box_collision_check.sv
// ----------------------------------------------------------------------------
// tile_and_box_collision_check
// Tile map and bounding box collision check over a tile map, a solid-tile
// set and an entity table, each held in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------------
//  item in   | start, busy         | operation, tile_id, cell_x, cell_y, slot,
//            |                     | pos_x, pos_y, box_width, box_height,
//            |                     | is_active, is_solid
//  result    | done (one cycle)    | place_free, blocked_by_tile,
//            |                     | blocked_by_entity
//  config    | cfg_we              | cfg_wdata (entity_count)
//
//  clear, map write and entity write complete on acceptance; mark
//  solid adds ST_MARK (read-modify-write of an 8-bit row of the solid set).
//  a query passes ST_SOLID and ST_TEST per corner (map read, then solid
//  read), up to four corners, then ST_ENT per entity slot walked, up to MAX_ENTITIES.
//  done rises in the cycle after the last step, with busy already low.
//  reset clears the solid set via per-row valid bits; the receiver cannot stall.
// ----------------------------------------------------------------------------
module tile_and_box_collision_check #(
    parameter int MAX_ENTITIES = tbcc_pkg::MAX_ENTITIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   operation,
    input  logic [7:0]                   tile_id,
    input  logic [4:0]                   cell_x,
    input  logic [4:0]                   cell_y,
    input  logic [tbcc_pkg::SLOT_W-1:0]  slot,
    input  logic [7:0]                   pos_x,
    input  logic [7:0]                   pos_y,
    input  logic [7:0]                   box_width,
    input  logic [7:0]                   box_height,
    input  logic                         is_active,
    input  logic                         is_solid,
    input  logic                         cfg_we,
    input  logic [tbcc_pkg::COUNT_W-1:0] cfg_wdata,
    output logic                         done,
    output logic                         place_free,
    output logic                         blocked_by_tile,
    output logic                         blocked_by_entity
);
    import tbcc_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
    localparam int IDX_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // memories
    logic [7:0]  map_mem   [MAP_CELLS*MAP_CELLS];
    logic [7:0]  solid_mem [SOLID_ROWS];
    ent_rec_t    ent_mem   [MAX_ENTITIES];

    logic [7:0]            map_rdata_reg;
    logic [7:0]            solid_rdata_reg;
    ent_rec_t              ent_rdata_reg;
    logic [SOLID_ROWS-1:0] row_valid_reg;
    logic                  row_valid_rd_reg;

    // control
    state_t             state_reg, state_next;
    logic [1:0]         corner_reg, corner_next;
    logic [CNT_W-1:0]   ent_idx_reg, ent_idx_next;
    logic [COUNT_W-1:0] entity_count_reg;
    logic               done_reg, done_next;

    // item payload held during a query or a mark
    logic [7:0]        px_reg, py_reg, bw_reg, bh_reg, rx_reg, by_reg, tid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [2:0]        bit_reg;
    logic              place_free_reg, place_free_next;
    logic              by_tile_reg, by_tile_next;
    logic              by_ent_reg, by_ent_next;

    op_t                  op;
    logic                 accept;
    logic [MAP_ADDR_W-1:0] map_raddr;
    logic [SOLID_ROW_W-1:0] solid_raddr;
    logic [IDX_W-1:0]     ent_raddr;
    logic                 ent_rd_en;
    logic [7:0]           cx_sel, cy_sel;
    logic [1:0]           corner_inc;
    logic [CMP_W-1:0]     slot_ext, count_ext, n_cmp;
    logic [CNT_W-1:0]     ent_n, ent_idx_inc;
    logic                 slot_ok;
    logic                 tile_hit, ent_hit, ent_last;
    logic                 ovl_x, ovl_y;
    logic [7:0]           mark_row;

    assign op     = op_t'(operation);
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign slot_ext  = CMP_W'(slot);
    assign slot_ok   = (slot_ext < CMP_W'(MAX_ENTITIES));
    assign count_ext = CMP_W'(entity_count_reg);
    assign n_cmp     = (count_ext > CMP_W'(MAX_ENTITIES)) ? CMP_W'(MAX_ENTITIES) : count_ext;
    assign ent_n     = n_cmp[CNT_W-1:0];

    assign corner_inc  = corner_reg + 2'd1;
    assign ent_idx_inc = ent_idx_reg + CNT_W'(1);
    assign ent_last    = (ent_idx_inc == ent_n);

    // corner order: bit 1 picks the right edge, bit 0 the bottom edge
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            cx_sel = pos_x;
            cy_sel = pos_y;
        end
        else
        begin
            cx_sel = corner_inc[1] ? rx_reg : px_reg;
            cy_sel = corner_inc[0] ? by_reg : py_reg;
        end
    end

    assign map_raddr   = {cy_sel[7:3], cx_sel[7:3]};
    assign solid_raddr = (state_reg == ST_SOLID) ? map_rdata_reg[7:3] : tile_id[7:3];
    assign ent_raddr   = ent_idx_next[IDX_W-1:0];
    assign ent_rd_en   = (state_next == ST_ENT);

    assign tile_hit = row_valid_rd_reg && solid_rdata_reg[bit_reg];

    // strict overlap in 9-bit unwrapped sums
    assign ovl_x = ({1'b0, px_reg} < ({1'b0, ent_rdata_reg.x} + {1'b0, ent_rdata_reg.w}))
                && (({1'b0, px_reg} + {1'b0, bw_reg}) > {1'b0, ent_rdata_reg.x});
    assign ovl_y = ({1'b0, py_reg} < ({1'b0, ent_rdata_reg.y} + {1'b0, ent_rdata_reg.h}))
                && (({1'b0, py_reg} + {1'b0, bh_reg}) > {1'b0, ent_rdata_reg.y});
    assign ent_hit = ent_rdata_reg.active && ent_rdata_reg.solid
                  && (CMP_W'(ent_idx_reg) != CMP_W'(slot_reg)) && ovl_x && ovl_y;

    assign mark_row = (row_valid_rd_reg ? solid_rdata_reg : 8'd0) | (8'd1 << tid_reg[2:0]);

    // next state
    always_comb
    begin
        state_next   = state_reg;
        corner_next  = corner_reg;
        ent_idx_next = ent_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                corner_next = 2'd0;
                if (accept)
                begin
                    if (op == OP_MARK)
                        state_next = ST_MARK;
                    else if (op == OP_QUERY)
                        state_next = ST_SOLID;
                end
            end
            ST_MARK:
                state_next = ST_IDLE;
            ST_SOLID:
                state_next = ST_TEST;
            ST_TEST:
            begin
                ent_idx_next = '0;
                priority if (tile_hit)
                    state_next = ST_IDLE;
                else if (corner_reg != 2'd3)
                begin
                    state_next  = ST_SOLID;
                    corner_next = corner_inc;
                end
                else if (ent_n == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_ENT;
            end
            ST_ENT:
            begin
                if (ent_hit || ent_last)
                    state_next = ST_IDLE;
                else
                    ent_idx_next = ent_idx_inc;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        done_next       = 1'b0;
        place_free_next = 1'b1;
        by_tile_next    = 1'b0;
        by_ent_next     = 1'b0;
        if (state_reg == ST_TEST)
        begin
            if (tile_hit)
            begin
                done_next       = 1'b1;
                place_free_next = 1'b0;
                by_tile_next    = 1'b1;
            end
            else if ((corner_reg == 2'd3) && (ent_n == '0))
                done_next = 1'b1;
        end
        else if (state_reg == ST_ENT)
        begin
            if (ent_hit)
            begin
                done_next       = 1'b1;
                place_free_next = 1'b0;
                by_ent_next     = 1'b1;
            end
            else if (ent_last)
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            corner_reg       <= 2'd0;
            ent_idx_reg      <= '0;
            done_reg         <= 1'b0;
            entity_count_reg <= '0;
            row_valid_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            corner_reg  <= corner_next;
            ent_idx_reg <= ent_idx_next;
            done_reg    <= done_next;
            if (cfg_we)
                entity_count_reg <= cfg_wdata;
            if (accept && (op == OP_CLEAR))
                row_valid_reg <= '0;
            else if (state_reg == ST_MARK)
                row_valid_reg[tid_reg[7:3]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        place_free_reg <= place_free_next;
        by_tile_reg    <= by_tile_next;
        by_ent_reg     <= by_ent_next;
        if (accept)
        begin
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            bw_reg   <= box_width;
            bh_reg   <= box_height;
            rx_reg   <= pos_x + box_width - 8'd1;
            by_reg   <= pos_y + box_height - 8'd1;
            slot_reg <= slot;
            tid_reg  <= tile_id;
        end
        if (state_reg == ST_SOLID)
            bit_reg <= map_rdata_reg[2:0];
        row_valid_rd_reg <= row_valid_reg[solid_raddr];
    end

    // map memory
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_MAP_WR))
            map_mem[{cell_y, cell_x}] <= tile_id;
        map_rdata_reg <= map_mem[map_raddr];
    end

    // solid set rows, read-modify-write on mark
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MARK)
            solid_mem[tid_reg[7:3]] <= mark_row;
        solid_rdata_reg <= solid_mem[solid_raddr];
    end

    // entity table
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_ENT_WR) && slot_ok)
            ent_mem[slot_ext[IDX_W-1:0]] <= '{x: pos_x, y: pos_y, w: box_width,
                                              h: box_height, active: is_active,
                                              solid: is_solid};
        if (ent_rd_en)
            ent_rdata_reg <= ent_mem[ent_raddr];
    end

    assign done              = done_reg;
    assign place_free        = place_free_reg;
    assign blocked_by_tile   = by_tile_reg;
    assign blocked_by_entity = by_ent_reg;

endmodule
